>>> sv/slwc_pkg.sv
package slwc_pkg;

	// indication modes, same encoding as the indication code field
	typedef enum logic [2:0] {
		MODE_OPER     = 3'd0,
		MODE_SETUP    = 3'd1,
		MODE_PAIR     = 3'd2,
		MODE_PERSIST  = 3'd3,
		MODE_AWAIT    = 3'd4,
		MODE_SUCC     = 3'd5,
		MODE_ERROR    = 3'd6,
		MODE_CONFLICT = 3'd7
	} mode_t;

	// item actions
	typedef enum logic [1:0] {
		ACT_TICK        = 2'd0,
		ACT_INDICATE    = 2'd1,
		ACT_CLOSE_SETUP = 2'd2,
		ACT_CLOSE_PAIR  = 2'd3
	} action_t;

	// radio profile requests
	typedef enum logic [1:0] {
		PROF_NONE = 2'd0,
		PROF_OPER = 2'd1,
		PROF_COMM = 2'd2
	} profile_t;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_PAIRING_WINDOW = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ERROR_HOLD     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SETUP_WINDOW   = 3'd4;

	// register reset values
	localparam logic [23:0] PAIRING_WINDOW_RST = 24'd120000;
	localparam logic [15:0] DEBOUNCE_RST       = 16'd50;
	localparam logic [7:0]  BRIGHTNESS_RST     = 8'd20;
	localparam logic [15:0] ERROR_HOLD_RST     = 16'd3000;
	localparam logic [15:0] SETUP_WINDOW_RST   = 16'd300;

	// reciprocal of 125 for a 29 bit dividend, shift 36 (ms time / 1000 after >> 3)
	localparam logic [29:0] NOW_DIV_M = 30'd549755814;
	// reciprocal of 125 for a 23 bit dividend, shift 30 (seconds left)
	localparam logic [23:0] SEC_DIV_M = 24'd8589935;

	// remaining seconds caps, in ms of window left
	localparam logic [31:0] PAIR_CAP_MS = 32'd32767000;
	localparam logic [31:0] SETUP_CAP_MS = 32'd65535000;

endpackage

>>> sv/status_led_window_controller_core.sv
// pipeline: input register, stage two register and result register; one item per cycle
// unless result_stall holds it; stage one updates all window and button state
// from the input register, stage two renders the pattern and remaining seconds
// reset: arst_n clears the pipeline, mode, windows and button state at once and
// loads the default register values; no clearing pass is needed
module status_led_window_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  action,
	input  logic [31:0] now_ms,
	input  logic        button_low,
	input  logic        setup_required,
	input  logic        radio_ok,
	input  logic [2:0]  indication_code,
	input  logic [31:0] duration_ms,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [2:0]  mode,
	output logic [1:0]  profile_request,
	output logic        pairing_active,
	output logic        setup_active,
	output logic [14:0] pairing_remaining_s,
	output logic [15:0] setup_remaining_s,
	output logic        close_ok,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [slwc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [slwc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// pipeline handshake
	logic s1_valid_q, s2_valid_q, out_valid_q;
	logic out_free, s2_free, s1_free, s1_adv, s2_adv, item_acc;

	// configuration registers
	logic [23:0] pw_q;
	logic [15:0] deb_q;
	logic [7:0]  br_q;
	logic [15:0] eh_q;
	logic [15:0] sw_q;

	// input register
	slwc_pkg::action_t act_s1;
	logic [31:0] now_s1;
	logic        btn_s1, req_s1, rok_s1;
	logic [2:0]  code_s1;
	logic [31:0] dur_s1;

	// controller state
	slwc_pkg::mode_t mode_q, mode_n;
	logic [31:0] pdl_q, sdl_q, idl_q, pdl_n, sdl_n, idl_n;
	logic        pv_q, sv_q, iv_q, pv_n, sv_n, iv_n;
	logic        rawb_q, stab_q, rawb_n, stab_n;
	logic [31:0] rct_q, rct_n;

	// stage one working signals
	logic [31:0] p_left, s_left, p_elap, s_elap, i_elap, rct_elap;
	logic        p_reached, s_reached, p_fut, s_fut;
	logic [31:0] pw_ext, sw_ms, err_dl, pair_dl, setup_dl, ind_dl;
	logic        err1, i_hit, raw_chg, settle, pset, sset;
	slwc_pkg::profile_t prof_n;
	logic        close_n;
	logic [58:0] qprod;

	// stage two registers
	slwc_pkg::mode_t    mode_s2;
	slwc_pkg::profile_t prof_s2;
	logic        pv_s2, sa_s2, close_s2;
	logic [31:0] pdiff_s2, sdiff_s2;
	logic [22:0] q_s2;
	logic [9:0]  nlo_s2;

	// stage two working signals
	logic [9:0]  qk, ph;
	logic [8:0]  tri_w;
	logic [15:0] slvl_p;
	logic [26:0] plvl_p;
	logic [7:0]  slvl, plvl;
	logic        await_on, err_on, conf_on;
	logic [7:0]  r_n, g_n, b_n;
	logic        pa_n, sa_n, p_big, s_big;
	logic [25:0] psum, ssum;
	logic [15:0] psec, ssec;
	logic [14:0] prem_n;
	logic [15:0] srem_n;

	// result register
	logic [7:0]  red_q, green_q, blue_q;
	logic [2:0]  mode_o_q;
	logic [1:0]  prof_o_q;
	logic        pa_q, sa_q, close_q;
	logic [14:0] prem_q;
	logic [15:0] srem_q;

	// seconds helper: floor of x / 1000 for x below 65536000, via x >> 3 times reciprocal of 125
	function automatic logic [15:0] div1000(input logic [25:0] x);
		logic [46:0] p;
		p = 47'(x[25:3]) * 47'(slwc_pkg::SEC_DIV_M);
		return p[45:30];
	endfunction

	// handshake: each stage moves when the one after it has room
	assign out_free   = !out_valid_q || !result_stall;
	assign s2_free    = !s2_valid_q || out_free;
	assign s1_free    = !s1_valid_q || s2_free;
	assign s1_adv     = s1_valid_q && s2_free;
	assign s2_adv     = s2_valid_q && out_free;
	assign item_acc   = item_valid && s1_free;
	assign item_stall = !s1_free;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= item_valid;
			end
			if (s2_free) begin
				s2_valid_q <= s1_valid_q;
			end
			if (out_free) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q  <= slwc_pkg::PAIRING_WINDOW_RST;
			deb_q <= slwc_pkg::DEBOUNCE_RST;
			br_q  <= slwc_pkg::BRIGHTNESS_RST;
			eh_q  <= slwc_pkg::ERROR_HOLD_RST;
			sw_q  <= slwc_pkg::SETUP_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				slwc_pkg::REG_PAIRING_WINDOW: pw_q  <= cfg_data;
				slwc_pkg::REG_DEBOUNCE:       deb_q <= cfg_data[15:0];
				slwc_pkg::REG_BRIGHTNESS:     br_q  <= cfg_data[7:0];
				slwc_pkg::REG_ERROR_HOLD:     eh_q  <= cfg_data[15:0];
				slwc_pkg::REG_SETUP_WINDOW:   sw_q  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (item_acc) begin
			act_s1  <= slwc_pkg::action_t'(action);
			now_s1  <= now_ms;
			btn_s1  <= button_low;
			req_s1  <= setup_required;
			rok_s1  <= radio_ok;
			code_s1 <= indication_code;
			dur_s1  <= duration_ms;
		end
	end

	// wrap differences against the stored deadlines, all in parallel
	assign p_left    = pdl_q - now_s1;
	assign s_left    = sdl_q - now_s1;
	assign p_elap    = now_s1 - pdl_q;
	assign s_elap    = now_s1 - sdl_q;
	assign i_elap    = now_s1 - idl_q;
	assign rct_elap  = now_s1 - rct_q;
	assign p_reached = pv_q && !p_elap[31];
	assign s_reached = sv_q && !s_elap[31];
	assign p_fut     = (p_left != 32'd0) && !p_left[31];
	assign s_fut     = (s_left != 32'd0) && !s_left[31];

	// candidate deadlines
	assign pw_ext   = {8'd0, pw_q};
	assign sw_ms    = {16'd0, sw_q} * 32'd1000;
	assign err_dl   = now_s1 + {16'd0, eh_q};
	assign pair_dl  = now_s1 + pw_ext;
	assign setup_dl = now_s1 + sw_ms;
	assign ind_dl   = now_s1 + dur_s1;

	// time / 1000 quotient for the pattern phase
	assign qprod = 59'(now_s1[31:3]) * 59'(slwc_pkg::NOW_DIV_M);

	// next state for the item in the input register
	always_comb begin
		mode_n  = mode_q;
		pdl_n   = pdl_q;
		sdl_n   = sdl_q;
		idl_n   = idl_q;
		pv_n    = pv_q;
		sv_n    = sv_q;
		iv_n    = iv_q;
		rawb_n  = rawb_q;
		stab_n  = stab_q;
		rct_n   = rct_q;
		prof_n  = slwc_pkg::PROF_NONE;
		close_n = 1'b0;
		pset    = 1'b0;
		sset    = 1'b0;
		err1    = p_reached && !rok_s1;
		i_hit   = err1 ? (eh_q == 16'd0) : (iv_q && !i_elap[31]);
		raw_chg = btn_s1 != rawb_q;
		settle  = raw_chg ? (deb_q == 16'd0) : (rct_elap >= {16'd0, deb_q});
		case (act_s1)
			slwc_pkg::ACT_TICK: begin
				// pairing window expiry asks for the operational profile
				if (p_reached) begin
					pv_n   = 1'b0;
					prof_n = slwc_pkg::PROF_OPER;
					if (rok_s1) begin
						if (!iv_q) begin
							mode_n = slwc_pkg::MODE_OPER;
						end
					end else begin
						mode_n = slwc_pkg::MODE_ERROR;
						idl_n  = err_dl;
						iv_n   = 1'b1;
					end
				end
				// setup window expiry
				if (s_reached) begin
					sv_n   = 1'b0;
					mode_n = slwc_pkg::MODE_OPER;
				end
				// temporary indication expiry
				if (i_hit) begin
					iv_n   = 1'b0;
					mode_n = (pv_n && p_fut) ? slwc_pkg::MODE_PAIR : slwc_pkg::MODE_OPER;
				end
				// debounce
				if (raw_chg) begin
					rawb_n = btn_s1;
					rct_n  = now_s1;
				end
				if ((btn_s1 != stab_q) && settle) begin
					stab_n = btn_s1;
					if (btn_s1) begin
						if (req_s1) begin
							// press toggles the setup window
							if (sv_n && s_fut) begin
								sv_n   = 1'b0;
								mode_n = slwc_pkg::MODE_OPER;
							end else begin
								sdl_n  = setup_dl;
								sv_n   = 1'b1;
								sset   = 1'b1;
								mode_n = slwc_pkg::MODE_SETUP;
								iv_n   = 1'b0;
							end
						end else if (pv_n && p_fut) begin
							// press closes the pairing window, or enters error if the radio refuses
							prof_n = slwc_pkg::PROF_OPER;
							if (rok_s1) begin
								pv_n   = 1'b0;
								mode_n = slwc_pkg::MODE_OPER;
								iv_n   = 1'b0;
							end else begin
								mode_n = slwc_pkg::MODE_ERROR;
								idl_n  = err_dl;
								iv_n   = 1'b1;
							end
						end else begin
							// press opens the pairing window, or enters error if the radio refuses
							prof_n = slwc_pkg::PROF_COMM;
							if (rok_s1) begin
								pdl_n  = pair_dl;
								pv_n   = 1'b1;
								pset   = 1'b1;
								mode_n = slwc_pkg::MODE_PAIR;
								iv_n   = 1'b0;
							end else begin
								mode_n = slwc_pkg::MODE_ERROR;
								idl_n  = err_dl;
								iv_n   = 1'b1;
							end
						end
					end
				end
			end
			slwc_pkg::ACT_INDICATE: begin
				mode_n = slwc_pkg::mode_t'(code_s1);
				iv_n   = dur_s1 != 32'd0;
				idl_n  = ind_dl;
			end
			slwc_pkg::ACT_CLOSE_SETUP: begin
				sv_n   = 1'b0;
				mode_n = slwc_pkg::MODE_OPER;
				iv_n   = 1'b0;
			end
			slwc_pkg::ACT_CLOSE_PAIR: begin
				pv_n   = 1'b0;
				prof_n = slwc_pkg::PROF_OPER;
				if (rok_s1) begin
					mode_n  = slwc_pkg::MODE_OPER;
					iv_n    = 1'b0;
					close_n = 1'b1;
				end else begin
					mode_n = slwc_pkg::MODE_ERROR;
					idl_n  = err_dl;
					iv_n   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// controller state, updated as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= slwc_pkg::MODE_OPER;
			pdl_q  <= 32'd0;
			sdl_q  <= 32'd0;
			idl_q  <= 32'd0;
			pv_q   <= 1'b0;
			sv_q   <= 1'b0;
			iv_q   <= 1'b0;
			rawb_q <= 1'b0;
			stab_q <= 1'b0;
			rct_q  <= 32'd0;
		end else if (s1_adv) begin
			mode_q <= mode_n;
			pdl_q  <= pdl_n;
			sdl_q  <= sdl_n;
			idl_q  <= idl_n;
			pv_q   <= pv_n;
			sv_q   <= sv_n;
			iv_q   <= iv_n;
			rawb_q <= rawb_n;
			stab_q <= stab_n;
			rct_q  <= rct_n;
		end
	end

	// stage two register: mode, window time left and phase quotient
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			mode_s2  <= mode_n;
			prof_s2  <= prof_n;
			close_s2 <= close_n;
			pv_s2    <= pv_n;
			sa_s2    <= sv_n && req_s1;
			pdiff_s2 <= pset ? pw_ext : p_left;
			sdiff_s2 <= sset ? sw_ms : s_left;
			q_s2     <= qprod[58:36];
			nlo_s2   <= now_s1[9:0];
		end
	end

	// pattern phase, time mod 1000, and triangle ramp
	assign qk     = q_s2[9:0] * 10'd1000;
	assign ph     = nlo_s2 - qk;
	assign tri_w  = (ph < 10'd500) ? ph[8:0] : 9'(10'd1000 - ph);
	// ramp * 40 / 500 and ramp * 64 / 500 by reciprocal
	assign slvl_p = 16'(tri_w) * 16'd82;
	assign plvl_p = 27'(tri_w) * 27'd134224;
	assign slvl   = 8'd8 + 8'(slvl_p[15:10]);
	assign plvl   = 8'd8 + 8'(plvl_p[26:20]);

	assign await_on = (ph < 10'd125) || (ph >= 10'd250 && ph < 10'd375) ||
		(ph >= 10'd500 && ph < 10'd625) || (ph >= 10'd750 && ph < 10'd875);
	assign err_on = (ph < 10'd100) || (ph >= 10'd200 && ph < 10'd300) ||
		(ph >= 10'd400 && ph < 10'd500) || (ph >= 10'd600 && ph < 10'd700) ||
		(ph >= 10'd800 && ph < 10'd900);
	assign conf_on = (ph < 10'd100) || (ph >= 10'd200 && ph < 10'd300);

	// led levels per mode
	always_comb begin
		r_n = 8'd0;
		g_n = 8'd0;
		b_n = 8'd0;
		case (mode_s2)
			slwc_pkg::MODE_OPER: begin
				g_n = br_q;
			end
			slwc_pkg::MODE_SETUP: begin
				r_n = slvl;
				b_n = slvl;
			end
			slwc_pkg::MODE_PAIR: begin
				b_n = plvl;
			end
			slwc_pkg::MODE_PERSIST: begin
				if (ph < 10'd300) begin
					r_n = br_q;
					g_n = 8'd24;
				end
			end
			slwc_pkg::MODE_AWAIT: begin
				if (await_on) begin
					g_n = br_q;
					b_n = br_q;
				end
			end
			slwc_pkg::MODE_SUCC: begin
				r_n = br_q;
				g_n = br_q;
				b_n = br_q;
			end
			slwc_pkg::MODE_ERROR: begin
				if (err_on) begin
					r_n = br_q;
				end
			end
			slwc_pkg::MODE_CONFLICT: begin
				if (conf_on) begin
					r_n = br_q;
					b_n = br_q;
				end
			end
			default: begin
			end
		endcase
	end

	// window status and seconds left, rounded up and saturated
	assign pa_n   = pv_s2 && (pdiff_s2 != 32'd0) && !pdiff_s2[31];
	assign sa_n   = sa_s2 && (sdiff_s2 != 32'd0) && !sdiff_s2[31];
	assign p_big  = pdiff_s2 > slwc_pkg::PAIR_CAP_MS;
	assign s_big  = sdiff_s2 > slwc_pkg::SETUP_CAP_MS;
	assign psum   = pdiff_s2[25:0] + 26'd999;
	assign ssum   = sdiff_s2[25:0] + 26'd999;
	assign psec   = div1000(psum);
	assign ssec   = div1000(ssum);
	assign prem_n = !pa_n ? 15'd0 : (p_big ? 15'd32767 : psec[14:0]);
	assign srem_n = !sa_n ? 16'd0 : (s_big ? 16'd65535 : ssec);

	// result register
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			red_q    <= r_n;
			green_q  <= g_n;
			blue_q   <= b_n;
			mode_o_q <= mode_s2;
			prof_o_q <= prof_s2;
			pa_q     <= pa_n;
			sa_q     <= sa_n;
			prem_q   <= prem_n;
			srem_q   <= srem_n;
			close_q  <= close_s2;
		end
	end

	assign result_valid        = out_valid_q;
	assign red                 = red_q;
	assign green               = green_q;
	assign blue                = blue_q;
	assign mode                = mode_o_q;
	assign profile_request     = prof_o_q;
	assign pairing_active      = pa_q;
	assign setup_active        = sa_q;
	assign pairing_remaining_s = prem_q;
	assign setup_remaining_s   = srem_q;
	assign close_ok            = close_q;

`ifndef NO_ASSERTIONS
	// a successful close always comes with an operational profile request
	a_close_prof: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && close_ok |-> profile_request == slwc_pkg::PROF_OPER)
		else $error("close_ok without operational profile request");

	// an open pairing window always has time left
	a_pair_secs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pairing_active |-> pairing_remaining_s != 15'd0)
		else $error("pairing active with zero seconds left");

	// a closed setup window reports no time left
	a_setup_secs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !setup_active |-> setup_remaining_s == 16'd0)
		else $error("setup inactive with seconds left");

	// an item leaving the input register lands in stage two
	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> s2_valid_q)
		else $error("stage two lost an item");
`endif

endmodule

>>> tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import slwc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	// index outside the register map, must be ignored
	localparam logic [CFG_INDEX_W-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		action_t     action;
		logic [31:0] now_ms;
		logic        button_low;
		logic        setup_required;
		logic        radio_ok;
		mode_t       indication_code;
		logic [31:0] duration_ms;
	} tick_item_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		mode_t       mode;
		profile_t    profile;
		logic        pairing_active;
		logic        setup_active;
		logic [14:0] pairing_remaining_s;
		logic [15:0] setup_remaining_s;
		logic        close_ok;
	} led_status_t;

	typedef struct packed {
		tick_item_t  item;
		logic        typed;
		led_status_t status;
	} script_row_t;

	localparam led_status_t UNTYPED = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic [1:0] action;
	logic [31:0] now_ms;
	logic button_low;
	logic setup_required;
	logic radio_ok;
	logic [2:0] indication_code;
	logic [31:0] duration_ms;
	logic result_valid;
	logic result_stall;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [2:0] mode;
	logic [1:0] profile_request;
	logic pairing_active;
	logic setup_active;
	logic [14:0] pairing_remaining_s;
	logic [15:0] setup_remaining_s;
	logic close_ok;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	status_led_window_controller_core dut (.*);

	always #5 clk = ~clk;

	// controller image: registers
	logic [23:0] win_pair_ms;
	logic [15:0] win_debounce_ms;
	logic [7:0]  win_bright;
	logic [15:0] win_error_ms;
	logic [15:0] win_setup_s;

	// controller image: mode, deadlines and button
	mode_t       led_mode;
	logic [31:0] pair_due_ms, setup_due_ms, hold_due_ms;
	logic        pair_armed, setup_armed, hold_armed;
	logic        btn_raw, btn_stable;
	logic [31:0] btn_change_ms;
	profile_t    profile_asked;
	logic        radio_grant;

	led_status_t status_fifo[$];
	script_row_t script[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	// random stimulus state
	logic [31:0] wall_ms = 32'd0;
	logic held_level = 1'b0;
	int hold_left = 0;
	logic need_setup = 1'b0;

	function automatic logic is_due(input logic armed, input logic [31:0] now, dl);
		logic [31:0] d;
		d = now - dl;
		return armed && !d[31];
	endfunction

	function automatic logic is_ahead(input logic armed, input logic [31:0] now, dl);
		logic [31:0] d;
		d = dl - now;
		return armed && d != 32'd0 && !d[31];
	endfunction

	function automatic logic [31:0] secs_to(input logic [31:0] now, dl, cap);
		logic [31:0] s;
		s = (dl - now + 32'd999) / 32'd1000;
		return s > cap ? cap : s;
	endfunction

	function automatic logic ask_radio(input profile_t p);
		profile_asked = p;
		return radio_grant;
	endfunction

	function automatic void enter_error(input logic [31:0] now);
		led_mode = MODE_ERROR;
		hold_due_ms = now + {16'd0, win_error_ms};
		hold_armed = 1'b1;
	endfunction

	function automatic void flip_pairing(input logic [31:0] now);
		if (is_ahead(pair_armed, now, pair_due_ms)) begin
			if (ask_radio(PROF_OPER)) begin
				pair_armed = 1'b0;
				pair_due_ms = 32'd0;
				led_mode = MODE_OPER;
				hold_armed = 1'b0;
				hold_due_ms = 32'd0;
			end else begin
				enter_error(now);
			end
		end else begin
			if (ask_radio(PROF_COMM)) begin
				pair_due_ms = now + {8'd0, win_pair_ms};
				pair_armed = 1'b1;
				led_mode = MODE_PAIR;
				hold_armed = 1'b0;
				hold_due_ms = 32'd0;
			end else begin
				enter_error(now);
			end
		end
	endfunction

	// only called with setup required
	function automatic void flip_setup(input logic [31:0] now);
		if (is_ahead(setup_armed, now, setup_due_ms)) begin
			setup_armed = 1'b0;
			setup_due_ms = 32'd0;
			led_mode = MODE_OPER;
		end else begin
			setup_due_ms = now + {16'd0, win_setup_s} * 32'd1000;
			setup_armed = 1'b1;
			led_mode = MODE_SETUP;
			hold_armed = 1'b0;
			hold_due_ms = 32'd0;
		end
	endfunction

	function automatic void run_tick(input logic [31:0] now, input logic btn, input logic req);
		logic grant;
		// pairing window expiry switches the radio back
		if (is_due(pair_armed, now, pair_due_ms)) begin
			grant = ask_radio(PROF_OPER);
			pair_armed = 1'b0;
			pair_due_ms = 32'd0;
			if (grant) begin
				if (!hold_armed)
					led_mode = MODE_OPER;
			end else begin
				enter_error(now);
			end
		end
		if (is_due(setup_armed, now, setup_due_ms)) begin
			setup_armed = 1'b0;
			setup_due_ms = 32'd0;
			led_mode = MODE_OPER;
		end
		if (is_due(hold_armed, now, hold_due_ms)) begin
			hold_armed = 1'b0;
			hold_due_ms = 32'd0;
			led_mode = is_ahead(pair_armed, now, pair_due_ms) ? MODE_PAIR : MODE_OPER;
		end
		// debounce
		if (btn != btn_raw) begin
			btn_raw = btn;
			btn_change_ms = now;
		end
		if (btn != btn_stable && (now - btn_change_ms) >= {16'd0, win_debounce_ms}) begin
			btn_stable = btn;
			if (btn) begin
				if (req)
					flip_setup(now);
				else
					flip_pairing(now);
			end
		end
	endfunction

	// apply one item to the image and form its led status
	function automatic led_status_t advance_controller(input tick_item_t it);
		led_status_t s;
		logic [31:0] ph, ramp;
		logic pa, sa;
		s = '0;
		radio_grant = it.radio_ok;
		profile_asked = PROF_NONE;
		case (it.action)
			ACT_TICK: run_tick(it.now_ms, it.button_low, it.setup_required);
			ACT_INDICATE: begin
				led_mode = it.indication_code;
				hold_armed = it.duration_ms != 32'd0;
				hold_due_ms = hold_armed ? it.now_ms + it.duration_ms : 32'd0;
			end
			ACT_CLOSE_SETUP: begin
				setup_armed = 1'b0;
				setup_due_ms = 32'd0;
				led_mode = MODE_OPER;
				hold_armed = 1'b0;
				hold_due_ms = 32'd0;
			end
			default: begin
				pair_armed = 1'b0;
				pair_due_ms = 32'd0;
				if (ask_radio(PROF_OPER)) begin
					led_mode = MODE_OPER;
					hold_armed = 1'b0;
					hold_due_ms = 32'd0;
					s.close_ok = 1'b1;
				end else begin
					enter_error(it.now_ms);
				end
			end
		endcase

		// pattern at phase within the second
		ph = it.now_ms % 32'd1000;
		ramp = ph < 32'd500 ? ph : 32'd1000 - ph;
		case (led_mode)
			MODE_OPER: s.green = win_bright;
			MODE_SETUP: begin
				s.red = 8'(32'd8 + ramp * 32'd40 / 32'd500);
				s.blue = s.red;
			end
			MODE_PAIR: s.blue = 8'(32'd8 + ramp * 32'd64 / 32'd500);
			MODE_PERSIST: if (ph < 32'd300) begin
				s.red = win_bright;
				s.green = 8'd24;
			end
			MODE_AWAIT: if (ph % 32'd250 < 32'd125) begin
				s.green = win_bright;
				s.blue = win_bright;
			end
			MODE_SUCC: begin
				s.red = win_bright;
				s.green = win_bright;
				s.blue = win_bright;
			end
			MODE_ERROR: if (ph % 32'd200 < 32'd100)
				s.red = win_bright;
			default: if (ph < 32'd100 || (ph >= 32'd200 && ph < 32'd300)) begin
				s.red = win_bright;
				s.blue = win_bright;
			end
		endcase

		pa = is_ahead(pair_armed, it.now_ms, pair_due_ms);
		sa = it.setup_required && is_ahead(setup_armed, it.now_ms, setup_due_ms);
		s.mode = led_mode;
		s.profile = profile_asked;
		s.pairing_active = pa;
		s.setup_active = sa;
		s.pairing_remaining_s = pa ? 15'(secs_to(it.now_ms, pair_due_ms, 32'd32767)) : 15'd0;
		s.setup_remaining_s = sa ? 16'(secs_to(it.now_ms, setup_due_ms, 32'd65535)) : 16'd0;
		return s;
	endfunction

	// mostly small time steps with held button levels, some jumps and glitches
	function automatic tick_item_t random_item();
		tick_item_t it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70)
			wall_ms = wall_ms + $urandom_range(1, 30);
		else if (pick < 90)
			wall_ms = wall_ms + $urandom_range(31, 1000);
		else if (pick < 98)
			wall_ms = wall_ms + $urandom_range(1001, 70000);
		else
			wall_ms = $urandom;
		if (hold_left == 0) begin
			held_level = ~held_level;
			hold_left = $urandom_range(1, 15);
		end else begin
			hold_left--;
		end
		if ($urandom_range(99) < 4)
			need_setup = ~need_setup;

		pick = $urandom_range(99);
		if (pick < 80)
			it.action = ACT_TICK;
		else if (pick < 88)
			it.action = ACT_INDICATE;
		else if (pick < 93)
			it.action = ACT_CLOSE_SETUP;
		else
			it.action = ACT_CLOSE_PAIR;
		it.now_ms = wall_ms;
		it.button_low = ($urandom_range(99) < 8) ? ~held_level : held_level;
		it.setup_required = need_setup;
		it.radio_ok = $urandom_range(99) < 85;
		it.indication_code = mode_t'($urandom_range(7));
		pick = $urandom_range(99);
		if (pick < 30)
			it.duration_ms = 32'd0;
		else if (pick < 90)
			it.duration_ms = $urandom_range(1, 3000);
		else
			it.duration_ms = $urandom;
		return it;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// one item beat; returns at the accepting edge
	task automatic send_item(input tick_item_t it, input logic typed, input led_status_t status);
		led_status_t s;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		action <= it.action;
		now_ms <= it.now_ms;
		button_low <= it.button_low;
		setup_required <= it.setup_required;
		radio_ok <= it.radio_ok;
		indication_code <= it.indication_code;
		duration_ms <= it.duration_ms;
		do @(posedge clk); while (item_stall);
		s = advance_controller(it);
		status_fifo.push_back(typed ? status : s);
	endtask

	// hold off items until every status beat is back
	task automatic settle();
		item_valid <= 1'b0;
		while (status_fifo.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PAIRING_WINDOW: win_pair_ms = data;
			REG_DEBOUNCE: win_debounce_ms = data[15:0];
			REG_BRIGHTNESS: win_bright = data[7:0];
			REG_ERROR_HOLD: win_error_ms = data[15:0];
			REG_SETUP_WINDOW: win_setup_s = data[15:0];
			default: ; // unmapped index has no effect
		endcase
	endtask

	// all registers, with junk above the narrow fields
	task automatic load_regs(input logic [23:0] pw, input logic [15:0] db, input logic [7:0] br,
			input logic [15:0] eh, input logic [15:0] sw);
		logic [31:0] junk;
		junk = $urandom;
		put_reg(REG_PAIRING_WINDOW, pw);
		put_reg(REG_DEBOUNCE, {junk[7:0], db});
		put_reg(REG_BRIGHTNESS, {junk[23:8], br});
		put_reg(REG_ERROR_HOLD, {junk[15:8], eh});
		put_reg(REG_SETUP_WINDOW, {junk[31:24], sw});
		put_reg(REG_NONE, junk[23:0]);
		cfg_valid <= 1'b0;
	endtask

	// status beat checker and receiver stall
	always @(posedge clk) begin : collect
		led_status_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (status_fifo.size() == 0) begin
				$error("status beat with no item pending");
				mismatch_count++;
			end else begin
				want = status_fifo.pop_front();
				check_field("red", 32'(want.red), 32'(red));
				check_field("green", 32'(want.green), 32'(green));
				check_field("blue", 32'(want.blue), 32'(blue));
				check_field("mode", 32'(want.mode), 32'(mode));
				check_field("profile_request", 32'(want.profile), 32'(profile_request));
				check_field("pairing_active", 32'(want.pairing_active),
					32'(pairing_active));
				check_field("setup_active", 32'(want.setup_active), 32'(setup_active));
				check_field("pairing_remaining_s", 32'(want.pairing_remaining_s),
					32'(pairing_remaining_s));
				check_field("setup_remaining_s", 32'(want.setup_remaining_s),
					32'(setup_remaining_s));
				check_field("close_ok", 32'(want.close_ok), 32'(close_ok));
			end
		end
		result_stall <= arst_n && stall_pct != 0 && $urandom_range(99) < stall_pct;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : run
		script_row_t row;
		int phase;
		int n;

		arst_n <= 1'b0;
		item_valid <= 1'b0;
		action <= ACT_TICK;
		now_ms <= 32'd0;
		button_low <= 1'b0;
		setup_required <= 1'b0;
		radio_ok <= 1'b0;
		indication_code <= MODE_OPER;
		duration_ms <= 32'd0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_PAIRING_WINDOW;
		cfg_data <= '0;

		// image after reset
		win_pair_ms = PAIRING_WINDOW_RST;
		win_debounce_ms = DEBOUNCE_RST;
		win_bright = BRIGHTNESS_RST;
		win_error_ms = ERROR_HOLD_RST;
		win_setup_s = SETUP_WINDOW_RST;
		led_mode = MODE_OPER;
		pair_due_ms = 32'd0;
		setup_due_ms = 32'd0;
		hold_due_ms = 32'd0;
		pair_armed = 1'b0;
		setup_armed = 1'b0;
		hold_armed = 1'b0;
		btn_raw = 1'b0;
		btn_stable = 1'b0;
		btn_change_ms = 32'd0;
		profile_asked = PROF_NONE;
		radio_grant = 1'b0;

		// directed script at reset register values
		// item: action, now, button, setup req, radio ok, code, duration | typed | status
		// status: r, g, b, mode, profile, pair act, setup act, pair s, setup s, close ok
		script.push_back({ACT_TICK, 32'd0, 1'b0, 1'b0, 1'b0, MODE_OPER, 32'd0, 1'b1,
			8'd0, 8'd20, 8'd0, MODE_OPER, PROF_NONE, 1'b0, 1'b0, 15'd0, 16'd0, 1'b0});
		// failed close of pairing goes to error
		script.push_back({ACT_CLOSE_PAIR, 32'd0, 1'b0, 1'b0, 1'b0, MODE_OPER, 32'd0, 1'b1,
			8'd20, 8'd0, 8'd0, MODE_ERROR, PROF_OPER, 1'b0, 1'b0, 15'd0, 16'd0, 1'b0});
		script.push_back({ACT_TICK, 32'd3000, 1'b0, 1'b0, 1'b0, MODE_OPER, 32'd0, 1'b0, UNTYPED});
		script.push_back({ACT_CLOSE_PAIR, 32'd3500, 1'b0, 1'b0, 1'b1, MODE_OPER, 32'd0, 1'b1,
			8'd0, 8'd20, 8'd0, MODE_OPER, PROF_OPER, 1'b0, 1'b0, 15'd0, 16'd0, 1'b1});
		script.push_back({ACT_CLOSE_SETUP, 32'd3600, 1'b0, 1'b1, 1'b0, MODE_OPER, 32'd0,
			1'b0, UNTYPED});
		// persist, await, success and conflict patterns, holds of zero, one and all ones
		script.push_back({ACT_INDICATE, 32'd4100, 1'b0, 1'b0, 1'b0, MODE_PERSIST, 32'd0,
			1'b0, UNTYPED});
		script.push_back({ACT_INDICATE, 32'd4260, 1'b0, 1'b0, 1'b0, MODE_AWAIT, 32'd1,
			1'b0, UNTYPED});
		script.push_back({ACT_INDICATE, 32'd4375, 1'b0, 1'b0, 1'b0, MODE_SUCC, 32'd0,
			1'b0, UNTYPED});
		script.push_back({ACT_INDICATE, 32'd4999, 1'b0, 1'b0, 1'b0, MODE_CONFLICT,
			32'hFFFF_FFFF, 1'b0, UNTYPED});
		// press opens pairing, release, press with radio refusal
		script.push_back({ACT_TICK, 32'd5000, 1'b1, 1'b0, 1'b1, MODE_OPER, 32'd0, 1'b0, UNTYPED});
		script.push_back({ACT_TICK, 32'd5050, 1'b1, 1'b0, 1'b1, MODE_OPER, 32'd0, 1'b0, UNTYPED});
		script.push_back({ACT_TICK, 32'd5100, 1'b0, 1'b0, 1'b1, MODE_OPER, 32'd0, 1'b0, UNTYPED});
		script.push_back({ACT_TICK, 32'd5150, 1'b0, 1'b0, 1'b1, MODE_OPER, 32'd0, 1'b0, UNTYPED});
		script.push_back({ACT_TICK, 32'd5200, 1'b1, 1'b0, 1'b0, MODE_OPER, 32'd0, 1'b0, UNTYPED});
		script.push_back({ACT_TICK, 32'd5250, 1'b1, 1'b0, 1'b0, MODE_OPER, 32'd0, 1'b1,
			8'd20, 8'd0, 8'd0, MODE_ERROR, PROF_OPER, 1'b1, 1'b0, 15'd120, 16'd0, 1'b0});
		// release, then press with setup required opens setup
		script.push_back({ACT_TICK, 32'd5300, 1'b0, 1'b0, 1'b1, MODE_OPER, 32'd0, 1'b0, UNTYPED});
		script.push_back({ACT_TICK, 32'd5350, 1'b0, 1'b0, 1'b1, MODE_OPER, 32'd0, 1'b0, UNTYPED});
		script.push_back({ACT_TICK, 32'd5400, 1'b1, 1'b1, 1'b1, MODE_OPER, 32'd0, 1'b0, UNTYPED});
		script.push_back({ACT_TICK, 32'd5450, 1'b1, 1'b1, 1'b1, MODE_OPER, 32'd0, 1'b0, UNTYPED});
		// backward jump saturates both second counts
		script.push_back({ACT_TICK, 32'd4224972746, 1'b1, 1'b1, 1'b1, MODE_OPER, 32'd0,
			1'b0, UNTYPED});
		// hold deadline that wraps to zero stays armed
		script.push_back({ACT_INDICATE, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1, MODE_AWAIT, 32'd16,
			1'b0, UNTYPED});
		script.push_back({ACT_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, MODE_OPER, 32'd0,
			1'b0, UNTYPED});
		script.push_back({ACT_TICK, 32'd0, 1'b1, 1'b1, 1'b1, MODE_OPER, 32'd0, 1'b0, UNTYPED});
		script.push_back({ACT_INDICATE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, MODE_OPER, 32'd0,
			1'b0, UNTYPED});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < script.size(); n++) begin
			row = script[n];
			send_item(row.item, row.typed, row.status);
		end
		settle();

		// phases of register settings and idling patterns
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 83; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 83; end
				default: begin send_idle_pct = 30; stall_pct = 30; end
			endcase
			if (phase == 1)
				load_regs(24'd0, 16'd0, 8'd0, 16'd0, 16'd0);
			else if (phase == 2)
				load_regs(24'hFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
			else if (phase != 0)
				load_regs(24'($urandom_range(1, 5000)), 16'($urandom_range(0, 100)),
					8'($urandom_range(255)), 16'($urandom_range(1, 4000)),
					16'($urandom_range(0, 5)));
			for (n = 0; n < 128; n++) begin
				if (n == 64)
					settle();
				send_item(random_item(), 1'b0, UNTYPED);
			end
			settle();
		end

		if (mismatch_count == 0 && status_fifo.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> status_led_window_controller_core.f
sv/slwc_pkg.sv
sv/status_led_window_controller_core.sv
tb/testbench.sv
